FILE: rtl/spr_pkg.sv
// Shared types for the serial packet receiver: event codes, result record,
// preamble constants and the reflected CCITT byte update.
// No dependencies.
package spr_pkg;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_BODY = 2'd1,
    EV_GOOD = 2'd2,
    EV_BAD  = 2'd3
  } spr_event_e;

  localparam logic [7:0]  PREAMBLE_0 = 8'hFF;
  localparam logic [7:0]  PREAMBLE_1 = 8'h09;
  localparam logic [15:0] CRC_INIT_RESET = 16'h00FF;

  typedef struct packed {
    logic [31:0] packets_good;
    logic [31:0] packets_seen;
    logic [7:0]  pkt_size;
    logic [7:0]  pkt_type;
    logic [7:0]  byte_index;
    logic [7:0]  data_byte;
    spr_event_e  event_res;
  } spr_res_t;

  // Reflected CCITT (0x8408) update of one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'b0000};
    return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
  endfunction

endpackage

FILE: rtl/spr_deframer.sv
// Packet deframer: phase state machine, CRC accumulator and packet counters.
// Produces the result of the current transaction combinationally. Uses spr_pkg.
module spr_deframer
  import spr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        accept_i,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  output spr_res_t    res_o
);

  typedef enum logic [3:0] {
    PH_HUNT1  = 4'd0,
    PH_HUNT2  = 4'd1,
    PH_SIZE   = 4'd2,
    PH_TYPE   = 4'd3,
    PH_BODY   = 4'd4,
    PH_CRC_LO = 4'd5,
    PH_CRC_HI = 4'd6,
    PH_SKIP1  = 4'd7,
    PH_SKIP2  = 4'd8
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] crc_init_q;
  logic [7:0]  body_len_q, body_len_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  body_cnt_q, body_cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [31:0] seen_q, seen_d;
  logic [31:0] good_q, good_d;
  spr_event_e  ev;
  logic [7:0]  dbyte;
  logic [7:0]  idx;

  always_comb begin
    phase_d    = phase_q;
    body_len_d = body_len_q;
    type_d     = type_q;
    body_cnt_d = body_cnt_q;
    crc_d      = crc_q;
    crc_lo_d   = crc_lo_q;
    seen_d     = seen_q;
    good_d     = good_q;
    ev         = EV_NONE;
    dbyte      = 8'h00;
    idx        = 8'h00;
    if (func_i) begin
      phase_d = PH_HUNT1;
    end else begin
      case (phase_q)
        PH_HUNT2: begin
          phase_d = (rx_byte_i == PREAMBLE_1) ? PH_SIZE : PH_HUNT1;
        end
        PH_SIZE: begin
          body_len_d = rx_byte_i;
          phase_d    = PH_TYPE;
        end
        PH_TYPE: begin
          type_d     = rx_byte_i;
          crc_d      = crc_byte(crc_init_q, rx_byte_i);
          body_cnt_d = 8'h00;
          phase_d    = (body_len_q == 8'h00) ? PH_CRC_LO : PH_BODY;
        end
        PH_BODY: begin
          ev         = EV_BODY;
          dbyte      = rx_byte_i;
          idx        = body_cnt_q;
          crc_d      = crc_byte(crc_q, rx_byte_i);
          body_cnt_d = body_cnt_q + 8'd1;
          if (body_cnt_d >= body_len_q) phase_d = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_lo_d = rx_byte_i;
          phase_d  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          seen_d = seen_q + 32'd1;
          if ({rx_byte_i, crc_lo_q} == crc_q) begin
            good_d  = good_q + 32'd1;
            ev      = EV_GOOD;
            phase_d = PH_SKIP1;
          end else begin
            ev      = EV_BAD;
            phase_d = PH_HUNT1;
          end
        end
        PH_SKIP1: phase_d = PH_SKIP2;
        PH_SKIP2: phase_d = PH_SIZE;
        default: begin
          type_d     = 8'h00;
          body_len_d = 8'h00;
          phase_d    = (rx_byte_i == PREAMBLE_0) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  always_comb begin
    res_o.event_res    = ev;
    res_o.data_byte    = dbyte;
    res_o.byte_index   = idx;
    res_o.pkt_type     = type_d;
    res_o.pkt_size     = body_len_d;
    res_o.packets_seen = seen_d;
    res_o.packets_good = good_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_init_q <= CRC_INIT_RESET;
    end else if (cfg_we_i) begin
      crc_init_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT1;
      body_len_q <= 8'h00;
      type_q     <= 8'h00;
      body_cnt_q <= 8'h00;
      crc_q      <= 16'h0000;
      crc_lo_q   <= 8'h00;
      seen_q     <= 32'h0;
      good_q     <= 32'h0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      body_len_q <= body_len_d;
      type_q     <= type_d;
      body_cnt_q <= body_cnt_d;
      crc_q      <= crc_d;
      crc_lo_q   <= crc_lo_d;
      seen_q     <= seen_d;
      good_q     <= good_d;
    end
  end

endmodule

FILE: rtl/spr_out_reg.sv
// Result register for the master stream; loads whenever empty or being drained.
// Uses spr_pkg.
module spr_out_reg
  import spr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_valid_i,
  output logic     load_ready_o,
  input  spr_res_t res_i,
  output logic     valid_o,
  input  logic     ready_i,
  output spr_res_t res_o
);

  logic     valid_q;
  spr_res_t res_q;

  assign load_ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && load_ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: rtl/serial_packet_receiver_crc16_top.sv
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid_i/tready_o  tdata: rx_byte; tuser: func
// m_axis    out  m_axis_tvalid_o/tready_i  tdata: result fields; tuser: event_res
// cfg       in   cfg_we_i                  cfg_wdata_i: crc_init
// One transaction per cycle; each input transaction yields one result in the next cycle.
// Throughput is set by the single output register: input stalls only while it is full
// and not drained. Reset returns to preamble hunt, counters zero, crc_init 0x00FF.
// Top level: instantiates spr_deframer and spr_out_reg; uses spr_pkg.
module serial_packet_receiver_crc16_top
  import spr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // crc_init
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i, // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser_i, // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] data_byte, [15:8] byte_index, [23:16] pkt_type, [31:24] pkt_size,
  // [63:32] packets_seen, [95:64] packets_good
  output logic [95:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o  // [1:0] event_res
);

  spr_res_t res_d;
  spr_res_t res_q;
  logic     accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  spr_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .func_i      (s_axis_tuser_i[0]),
    .rx_byte_i   (s_axis_tdata_i),
    .res_o       (res_d)
  );

  spr_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s_axis_tvalid_i),
    .load_ready_o (s_axis_tready_o),
    .res_i        (res_d),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .res_o        (res_q)
  );

  assign m_axis_tdata_o = {res_q.packets_good, res_q.packets_seen, res_q.pkt_size,
                           res_q.pkt_type, res_q.byte_index, res_q.data_byte};
  assign m_axis_tuser_o = res_q.event_res;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while result is stalled");

  a_abort_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser_i[0]) |=> (m_axis_tvalid_o && m_axis_tuser_o == EV_NONE))
    else $error("abort produced an event");

  a_body_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != EV_BODY) |->
      (m_axis_tdata_o[15:0] == 16'h0000))
    else $error("data byte or index set outside body event");

  a_good_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_d.event_res == EV_GOOD) |=>
      (m_axis_tdata_o[95:64] == $past(res_d.packets_good)))
    else $error("good packet result not registered");

endmodule

FILE: verif/spr_checker.sv
// Scoreboard for the serial packet receiver: a deframer/CRC16 predictor fed by accepted
// input transactions, compared field by field against accepted result transactions.
// Depends on spr_pkg (event codes, result record, preamble bytes, crc_init reset value).
package spr_tb_pkg;

  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_ABORT = 1'b1;

  // Bitwise reflected CCITT, poly 0x8408.
  function automatic logic [15:0] crc16_ccitt_refl(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int i;
    c = crc ^ {8'h00, b};
    for (i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module spr_checker
  import spr_pkg::*;
  import spr_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic [0:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [95:0] m_axis_tdata_i,
  input  logic [1:0]  m_axis_tuser_i,
  output int          mismatches_o,
  output int          pending_o
);

  typedef enum logic [3:0] {
    ST_HUNT_FF, ST_HUNT_09, ST_SIZE, ST_TYPE, ST_BODY,
    ST_CRC_LO, ST_CRC_HI, ST_SKIP_A, ST_SKIP_B
  } rx_phase_e;

  rx_phase_e   phase;
  logic [15:0] seed;
  logic [7:0]  body_len;
  logic [7:0]  type_byte;
  logic [7:0]  body_cnt;
  logic [15:0] crc_run;
  logic [7:0]  crc_lo;
  logic [31:0] seen_cnt;
  logic [31:0] good_cnt;

  spr_res_t expected_results[$];

  function automatic spr_res_t deframe_step(input logic func, input logic [7:0] b);
    spr_res_t r;
    r = '0;
    r.event_res = EV_NONE;
    if (func == FUNC_ABORT) begin
      phase = ST_HUNT_FF;
    end else begin
      case (phase)
        ST_HUNT_09: begin
          phase = (b == PREAMBLE_1) ? ST_SIZE : ST_HUNT_FF;
        end
        ST_SIZE: begin
          body_len = b;
          phase = ST_TYPE;
        end
        ST_TYPE: begin
          type_byte = b;
          crc_run = crc16_ccitt_refl(seed, b);
          body_cnt = 8'd0;
          phase = (body_len == 8'd0) ? ST_CRC_LO : ST_BODY;
        end
        ST_BODY: begin
          r.event_res = EV_BODY;
          r.data_byte = b;
          r.byte_index = body_cnt;
          crc_run = crc16_ccitt_refl(crc_run, b);
          body_cnt = body_cnt + 8'd1;
          if (body_cnt >= body_len) phase = ST_CRC_LO;
        end
        ST_CRC_LO: begin
          crc_lo = b;
          phase = ST_CRC_HI;
        end
        ST_CRC_HI: begin
          seen_cnt = seen_cnt + 32'd1;
          if ({b, crc_lo} == crc_run) begin
            good_cnt = good_cnt + 32'd1;
            r.event_res = EV_GOOD;
            phase = ST_SKIP_A;
          end else begin
            r.event_res = EV_BAD;
            phase = ST_HUNT_FF;
          end
        end
        ST_SKIP_A: phase = ST_SKIP_B;
        ST_SKIP_B: phase = ST_SIZE;
        default: begin
          type_byte = 8'd0;
          body_len = 8'd0;
          phase = (b == PREAMBLE_0) ? ST_HUNT_09 : ST_HUNT_FF;
        end
      endcase
    end
    r.pkt_type = type_byte;
    r.pkt_size = body_len;
    r.packets_seen = seen_cnt;
    r.packets_good = good_cnt;
    return r;
  endfunction

  task automatic check_result();
    spr_res_t exp_r;
    spr_res_t got;
    got.event_res    = spr_event_e'(m_axis_tuser_i);
    got.data_byte    = m_axis_tdata_i[7:0];
    got.byte_index   = m_axis_tdata_i[15:8];
    got.pkt_type     = m_axis_tdata_i[23:16];
    got.pkt_size     = m_axis_tdata_i[31:24];
    got.packets_seen = m_axis_tdata_i[63:32];
    got.packets_good = m_axis_tdata_i[95:64];
    if (expected_results.size() == 0) begin
      mismatches_o++;
      if (mismatches_o <= 10)
        $display("unexpected result transaction: ev=%0d data=%h", got.event_res, got.data_byte);
    end else begin
      exp_r = expected_results.pop_front();
      if (got.event_res !== exp_r.event_res || got.data_byte !== exp_r.data_byte ||
          got.byte_index !== exp_r.byte_index || got.pkt_type !== exp_r.pkt_type ||
          got.pkt_size !== exp_r.pkt_size || got.packets_seen !== exp_r.packets_seen ||
          got.packets_good !== exp_r.packets_good) begin
        mismatches_o++;
        if (mismatches_o <= 10) begin
          $display("mismatch exp: ev=%0d data=%h idx=%0d type=%h size=%0d seen=%0d good=%0d",
                   exp_r.event_res, exp_r.data_byte, exp_r.byte_index, exp_r.pkt_type,
                   exp_r.pkt_size, exp_r.packets_seen, exp_r.packets_good);
          $display("         got: ev=%0d data=%h idx=%0d type=%h size=%0d seen=%0d good=%0d",
                   got.event_res, got.data_byte, got.byte_index, got.pkt_type,
                   got.pkt_size, got.packets_seen, got.packets_good);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase = ST_HUNT_FF;
      seed = CRC_INIT_RESET;
      body_len = 8'd0;
      type_byte = 8'd0;
      body_cnt = 8'd0;
      crc_run = 16'd0;
      crc_lo = 8'd0;
      seen_cnt = 32'd0;
      good_cnt = 32'd0;
      mismatches_o = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_results = {expected_results, deframe_step(s_axis_tuser_i[0], s_axis_tdata_i)};
      if (cfg_we_i) seed = cfg_wdata_i;
    end
    pending_o = expected_results.size();
  end

endmodule

FILE: verif/serial_packet_receiver_crc16_top_tb.sv
// Top of the serial packet receiver testbench: clock, reset, frame stimulus, crc_init
// phases and random back-pressure; spr_checker does the prediction and comparison.
// Depends on spr_pkg, spr_tb_pkg, spr_checker and serial_packet_receiver_crc16_top.
module serial_packet_receiver_crc16_top_tb
  import spr_pkg::*;
  import spr_tb_pkg::*;
();

  typedef enum int {FR_CLEAN, FR_BAD_CRC, FR_ABORT} frame_fault_e;

  localparam int LONG_HOLD = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  rx_tdata;
  logic [0:0]  rx_tuser;
  logic        res_valid;
  logic        res_ready;
  logic [95:0] res_tdata;
  logic [1:0]  res_tuser;

  int          mismatches;
  int          pending;
  int          items_sent;
  int          tx_burst;
  int          rx_burst;
  logic [15:0] crc_seed;
  bit          frame_resumed;

  serial_packet_receiver_crc16_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (rx_valid),
    .s_axis_tready_o (rx_ready),
    .s_axis_tdata_i  (rx_tdata),
    .s_axis_tuser_i  (rx_tuser),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_tdata),
    .m_axis_tuser_o  (res_tuser)
  );

  spr_checker scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (rx_valid),
    .s_axis_tready_i (rx_ready),
    .s_axis_tdata_i  (rx_tdata),
    .s_axis_tuser_i  (rx_tuser),
    .m_axis_tvalid_i (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_i  (res_tdata),
    .m_axis_tuser_i  (res_tuser),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  always #10 clk_i = ~clk_i;

  function automatic int idle_len(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 6);
    if (r < 97) return $urandom_range(7, 40);
    return $urandom_range(41, 254);
  endfunction

  task automatic offer_item(input logic func, input logic [7:0] b);
    int gap;
    gap = idle_len(tx_burst);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid <= 1'b1;
    rx_tuser <= func;
    rx_tdata <= b;
    @(posedge clk_i);
    while (!rx_ready) @(posedge clk_i);
    items_sent++;
  endtask

  // resume: header after a good packet, two skipped bytes instead of the preamble
  task automatic send_frame(input bit resume, input int size, input logic [7:0] ptype,
                            input frame_fault_e fault);
    logic [7:0]  bytes[$];
    logic [7:0]  b;
    logic [15:0] crc;
    int          cut;
    int          i;
    bytes = {};
    if (resume) begin
      bytes = {bytes, 8'($urandom)};
      bytes = {bytes, 8'($urandom)};
    end else begin
      bytes = {bytes, PREAMBLE_0};
      bytes = {bytes, PREAMBLE_1};
    end
    bytes = {bytes, 8'(size)};
    bytes = {bytes, ptype};
    crc = crc16_ccitt_refl(crc_seed, ptype);
    for (i = 0; i < size; i++) begin
      b = 8'($urandom);
      bytes = {bytes, b};
      crc = crc16_ccitt_refl(crc, b);
    end
    if (fault == FR_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    bytes = {bytes, crc[7:0]};
    bytes = {bytes, crc[15:8]};
    cut = (fault == FR_ABORT) ? $urandom_range(0, bytes.size() - 1) : bytes.size();
    for (i = 0; i < cut; i++) offer_item(FUNC_BYTE, bytes[i]);
    if (fault == FR_ABORT) offer_item(FUNC_ABORT, 8'($urandom));
    frame_resumed = (fault == FR_CLEAN);
  endtask

  task automatic wait_idle();
    rx_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    crc_seed = v;
  endtask

  // Result side: random stalls plus two long hold-offs so the input backs up.
  initial begin
    int cyc;
    int holds;
    int stall;
    int k;
    cyc = 0;
    holds = 0;
    rx_burst = 0;
    res_ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (holds < 2 && cyc >= 1500 + holds * 2500) begin
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        cyc += LONG_HOLD;
        holds++;
      end
      stall = idle_len(rx_burst);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        cyc += stall;
      end
      res_ready <= 1'b1;
      k = $urandom_range(1, 8);
      repeat (k) @(posedge clk_i);
      cyc += k;
    end
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [15:0] phase_seed[4];
    int          ph;
    int          target;
    int          r;
    int          n;
    int          i;
    phase_seed[0] = 16'h0000;
    phase_seed[1] = 16'hFFFF;
    phase_seed[2] = 16'($urandom);
    phase_seed[3] = 16'($urandom);
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 16'd0;
    rx_valid <= 1'b0;
    rx_tdata <= 8'd0;
    rx_tuser <= FUNC_BYTE;
    items_sent = 0;
    tx_burst = 0;
    crc_seed = CRC_INIT_RESET;
    frame_resumed = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: abort in hunt, bad second preamble, empty body, resumed headers, bad CRC, aborted frame
    offer_item(FUNC_ABORT, 8'hFF);
    offer_item(FUNC_BYTE, PREAMBLE_0);
    offer_item(FUNC_BYTE, PREAMBLE_0);
    offer_item(FUNC_BYTE, PREAMBLE_1);
    send_frame(1'b0, 0, 8'h00, FR_CLEAN);
    send_frame(1'b1, 1, 8'hFF, FR_CLEAN);
    send_frame(1'b1, 1, 8'h80, FR_BAD_CRC);
    send_frame(1'b0, 3, 8'h7F, FR_ABORT);

    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_seed(phase_seed[ph]);
      target = items_sent + 320;
      if (ph == 1) send_frame(frame_resumed, 255, 8'($urandom), FR_CLEAN);
      while (items_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          send_frame(frame_resumed, pick_size(), 8'($urandom), FR_CLEAN);
        end else if (r < 84) begin
          send_frame(frame_resumed, pick_size(), 8'($urandom), FR_BAD_CRC);
        end else if (r < 93) begin
          send_frame(frame_resumed, pick_size(), 8'($urandom), FR_ABORT);
        end else begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++)
            offer_item(FUNC_BYTE, ($urandom_range(0, 2) == 0) ? PREAMBLE_0 : 8'($urandom));
          offer_item(FUNC_ABORT, 8'($urandom));
          frame_resumed = 1'b0;
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
